// ===== hw/rtl/xcrc_pkg.sv =====
// shared types and line codes for the xmodem-crc block receiver
package xcrc_pkg;

    // line control bytes
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // register reset values
    localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd10;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'((16000000 / 100) * 7);

    // register indexes on the config port
    localparam logic REG_RETRY_LIMIT   = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_END      = 3'd2,
        ST_CANCEL   = 3'd3,
        ST_TIMEOUT  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_NUM   = 3'd2,
        PH_CMPL  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCH  = 3'd5,
        PH_CRCL  = 3'd6,
        PH_DRAIN = 3'd7
    } phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [6:0] data_index;
        logic [7:0] data_byte;
        status_t    status;
    } result_t;

endpackage

// ===== hw/rtl/xmodem_crc_block_receiver.sv =====
// top level of the xmodem-crc block receiver: stream ports, registers, pipeline
//
// usage:
//  - input channel s_*: one item is a command in s_tuser (start, byte arrived,
//    timer tick, clear block counter) and the received line byte in s_tdata
//  - result channel m_*: exactly one item per input item, carrying the byte
//    to send back ('C', ACK or NAK), a delivered payload byte with its index,
//    and a status code (busy, block accepted, end, cancelled, timeout)
//  - apb port: retry_limit at 0x0, timeout_ticks at 0x4; write only while idle
//  - an input item goes through an input register, then one pass through the
//    framing/crc logic into the result register; throughput is one item per
//    cycle while m_tready is high
//  - payload bytes may show up again after a retry; keep them only once a
//    block accepted status follows
//  - reset (aresetn low, synchronous) empties both stages, puts the receiver
//    in idle with the block counter at zero and loads the register defaults
//  - when m_tready is low the result stage holds; the input stage still takes
//    one more item, after which s_tready drops until the result is taken
module xmodem_crc_block_receiver #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] data_valid, [16:10] data_index,
    // [24:17] data_byte, [27:25] status, [31:28] zero
    output logic [31:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xcrc_pkg::*;

    // configuration registers
    logic [7:0]  retry_limit_reg;
    logic [31:0] timeout_ticks_reg;
    logic        cfg_wr;

    // input stage
    logic        in_vld_reg;
    cmd_t        cmd_reg;
    logic [7:0]  rx_byte_reg;

    // result stage
    logic        out_vld_reg;
    result_t     res_reg;
    result_t     res_next;

    logic        advance;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_RETRY_LIMIT:   retry_limit_reg   <= pwdata[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RETRY_LIMIT:   prdata = {24'd0, retry_limit_reg};
            REG_TIMEOUT_TICKS: prdata = timeout_ticks_reg;
            default:           prdata = '0;
        endcase
    end

    // the input item moves into the logic pass when the result stage has room
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg     <= cmd_t'(s_tuser);
            rx_byte_reg <= s_tdata;
        end
    end

    xcrc_fsm #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .cmd           (cmd_reg),
        .rx_byte       (rx_byte_reg),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, res_reg.status, res_reg.data_byte, res_reg.data_index,
                       res_reg.data_valid, res_reg.tx_byte, res_reg.tx_valid};

`ifndef SYNTHESIS
    // both stages come out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_vld_reg)
        else $error("pipeline not empty after reset");

    // input side only stalls when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    // a payload byte never comes with a reply byte or a final status
    a_data_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.data_valid |-> !res_reg.tx_valid && res_reg.status == ST_BUSY)
        else $error("payload byte mixed with reply or status");

    // unused fields read as zero
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_reg.tx_valid |-> res_reg.tx_byte == 8'd0)
        else $error("tx byte set without tx valid");
`endif

endmodule

// ===== hw/rtl/xcrc_crc16.sv =====
// byte-wide crc-16/xmodem update
module xcrc_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import xcrc_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// ===== hw/rtl/xcrc_fsm.sv =====
// framing, sequence and timeout state machine, one item per step
module xcrc_fsm #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  xcrc_pkg::cmd_t    cmd,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        retry_limit,
    input  logic [31:0]       timeout_ticks,
    output xcrc_pkg::result_t result
);
    import xcrc_pkg::*;

    localparam logic [7:0] LAST_COUNT = 8'(BLOCK_BYTES);

    phase_t      phase_reg, phase_next;
    logic [7:0]  block_count_reg, block_count_next;
    logic [7:0]  retries_left_reg, retries_left_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  byte_position_reg, byte_position_next;
    logic [7:0]  header_number_reg, header_number_next;
    logic [7:0]  check_hi_reg, check_hi_next;
    logic        accept_new_reg, accept_new_next;
    logic [7:0]  reply_byte_reg, reply_byte_next;
    logic [31:0] idle_count_reg, idle_count_next;

    logic [15:0] crc_upd;
    logic [31:0] idle_inc;
    logic [7:0]  pos_inc;
    logic [7:0]  retries_dec;

    xcrc_crc16 u_crc (
        .crc_in  (running_crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign idle_inc    = (idle_count_reg == '1) ? idle_count_reg : idle_count_reg + 32'd1;
    assign pos_inc     = byte_position_reg + 8'd1;
    assign retries_dec = retries_left_reg - 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            block_count_reg   <= '0;
            retries_left_reg  <= '0;
            running_crc_reg   <= '0;
            byte_position_reg <= '0;
            header_number_reg <= '0;
            check_hi_reg      <= '0;
            accept_new_reg    <= 1'b0;
            reply_byte_reg    <= '0;
            idle_count_reg    <= '0;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            block_count_reg   <= block_count_next;
            retries_left_reg  <= retries_left_next;
            running_crc_reg   <= running_crc_next;
            byte_position_reg <= byte_position_next;
            header_number_reg <= header_number_next;
            check_hi_reg      <= check_hi_next;
            accept_new_reg    <= accept_new_next;
            reply_byte_reg    <= reply_byte_next;
            idle_count_reg    <= idle_count_next;
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        block_count_next   = block_count_reg;
        retries_left_next  = retries_left_reg;
        running_crc_next   = running_crc_reg;
        byte_position_next = byte_position_reg;
        header_number_next = header_number_reg;
        check_hi_next      = check_hi_reg;
        accept_new_next    = accept_new_reg;
        reply_byte_next    = reply_byte_reg;
        idle_count_next    = idle_count_reg;
        result             = '0;

        case (cmd)
            CMD_START: begin
                reply_byte_next   = (block_count_reg != 8'd0) ? CH_ACK : CH_C;
                retries_left_next = retry_limit;
                phase_next        = PH_WAIT;
                running_crc_next  = '0;
                idle_count_next   = '0;
                result.tx_valid   = 1'b1;
                result.tx_byte    = reply_byte_next;
            end
            CMD_CLEAR: begin
                block_count_next = '0;
            end
            CMD_BYTE: begin
                if (phase_reg != PH_IDLE) begin
                    idle_count_next = '0;
                    case (phase_reg)
                        PH_WAIT: begin
                            if (rx_byte == CH_EOT) begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = CH_ACK;
                                result.status   = ST_END;
                                phase_next      = PH_IDLE;
                            end else if (rx_byte == CH_CAN) begin
                                result.status = ST_CANCEL;
                                phase_next    = PH_IDLE;
                            end else if (rx_byte == CH_SOH) begin
                                phase_next = PH_NUM;
                            end else begin
                                phase_next = PH_DRAIN;
                            end
                        end
                        PH_NUM: begin
                            header_number_next = rx_byte;
                            phase_next         = PH_CMPL;
                        end
                        PH_CMPL: begin
                            if (~rx_byte != header_number_reg) begin
                                phase_next = PH_DRAIN;
                            end else if (header_number_reg == block_count_reg) begin
                                accept_new_next    = 1'b0;
                                byte_position_next = '0;
                                phase_next         = PH_DATA;
                            end else if (header_number_reg == block_count_reg + 8'd1) begin
                                accept_new_next    = 1'b1;
                                byte_position_next = '0;
                                phase_next         = PH_DATA;
                            end else begin
                                result.status = ST_CANCEL;
                                phase_next    = PH_IDLE;
                            end
                        end
                        PH_DATA: begin
                            running_crc_next = crc_upd;
                            if (accept_new_reg) begin
                                result.data_valid = 1'b1;
                                result.data_index = byte_position_reg[6:0];
                                result.data_byte  = rx_byte;
                            end
                            byte_position_next = pos_inc;
                            if (pos_inc >= LAST_COUNT) begin
                                phase_next = PH_CRCH;
                            end
                        end
                        PH_CRCH: begin
                            check_hi_next = rx_byte;
                            phase_next    = PH_CRCL;
                        end
                        PH_CRCL: begin
                            if ({check_hi_reg, rx_byte} != running_crc_reg) begin
                                phase_next = PH_DRAIN;
                            end else if (!accept_new_reg) begin
                                // duplicate block: ack right away and re-arm
                                reply_byte_next  = CH_ACK;
                                phase_next       = PH_WAIT;
                                running_crc_next = '0;
                                result.tx_valid  = 1'b1;
                                result.tx_byte   = CH_ACK;
                            end else begin
                                block_count_next = block_count_reg + 8'd1;
                                result.status    = ST_ACCEPTED;
                                phase_next       = PH_IDLE;
                            end
                        end
                        default: begin
                            // drain: swallow bytes
                        end
                    endcase
                end
            end
            CMD_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    idle_count_next = idle_inc;
                    if (idle_inc >= timeout_ticks) begin
                        if (phase_reg == PH_DRAIN) begin
                            reply_byte_next  = CH_NAK;
                            phase_next       = PH_WAIT;
                            running_crc_next = '0;
                            idle_count_next  = '0;
                            result.tx_valid  = 1'b1;
                            result.tx_byte   = CH_NAK;
                        end else begin
                            retries_left_next = retries_dec;
                            if (retries_dec != 8'd0) begin
                                if (phase_reg != PH_WAIT) begin
                                    reply_byte_next = CH_NAK;
                                end
                                phase_next       = PH_WAIT;
                                running_crc_next = '0;
                                idle_count_next  = '0;
                                result.tx_valid  = 1'b1;
                                result.tx_byte   = reply_byte_next;
                            end else begin
                                result.status = ST_TIMEOUT;
                                phase_next    = PH_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule
